// ----- hw/rtl/gvr_pkg.sv -----
// Shared widths, codes, word types and the quarter-wave sine table for the rotation core.
package gvr_pkg;

   localparam int ENCODER_BITS       = 13;
   localparam int TRIG_FRACTION_BITS = 15;
   localparam int SPEED_BITS         = 16;

   localparam int QUARTER_BITS  = ENCODER_BITS - 2;
   localparam int ADDR_BITS     = QUARTER_BITS + 1;
   localparam int ROM_DEPTH     = (1 << QUARTER_BITS) + 1;
   localparam int TRIG_MAG_BITS = TRIG_FRACTION_BITS + 1;
   localparam int TRIG_BITS     = TRIG_FRACTION_BITS + 2;
   // |trig| never exceeds 1.0, so one bit less than the full signed product
   localparam int PROD_BITS     = SPEED_BITS + TRIG_BITS - 1;
   localparam int SUM_BITS      = PROD_BITS + 1;

   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [ADDR_BITS-1:0] QUARTER_TURN = ADDR_BITS'(1) << QUARTER_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] REG_COMMON_ZERO   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIAGONAL_ZERO = CSR_INDEX_BITS'(1);

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef logic [TRIG_MAG_BITS-1:0] sine_rom_type [ROM_DEPTH];

   // ROM addresses and signs for one word, plus the speeds riding along
   typedef struct packed {
      logic [ADDR_BITS-1:0]         sin_addr;
      logic [ADDR_BITS-1:0]         cos_addr;
      logic                         sin_neg;
      logic                         cos_neg;
      logic signed [SPEED_BITS-1:0] forward_speed;
      logic signed [SPEED_BITS-1:0] sideways_speed;
   } angle_word_type;

   typedef struct packed {
      logic signed [TRIG_BITS-1:0]  sine;
      logic signed [TRIG_BITS-1:0]  cosine;
      logic signed [SPEED_BITS-1:0] forward_speed;
      logic signed [SPEED_BITS-1:0] sideways_speed;
   } trig_word_type;

   // Shift-and-subtract floor quotient, used only while building the table.
   function automatic longint unsigned floor_quotient(input longint unsigned num,
                                                      input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 64'd0;
      rem = 64'd0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Quarter-wave sine, Q2.30 Taylor series rounded half up to Q1.F, evaluated at elaboration.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned k;
      longint          sum;
      longint          v;
      bit              negative;
      for (int a = 0; a < ROM_DEPTH; a++) begin
         x        = (longint'(a) * HALF_PI_Q30) >> QUARTER_BITS;
         x2       = (x * x) >> 30;
         term     = x;
         sum      = longint'(x);
         k        = 64'd2;
         negative = 1'b1;
         while (term != 64'd0 && k < 64'd40) begin
            term = floor_quotient((term * x2) >> 30, k * (k + 64'd1));
            if (negative) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
            negative = !negative;
            k        = k + 64'd2;
         end
         if (sum < 0) begin
            sum = 0;
         end
         v = (sum + (longint'(1) << (29 - TRIG_FRACTION_BITS))) >>> (30 - TRIG_FRACTION_BITS);
         if (v > (longint'(1) << TRIG_FRACTION_BITS)) begin
            v = longint'(1) << TRIG_FRACTION_BITS;
         end
         rom[a] = TRIG_MAG_BITS'(v);
      end
      return rom;
   endfunction

endpackage

// ----- hw/rtl/gvr_channels.sv -----
// Handshake channel interfaces for request, response and register-write words.
interface gvr_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [gvr_pkg::ENCODER_BITS-1:0]      yaw_position;
   logic                                  diagonal_mode;
   logic signed [gvr_pkg::SPEED_BITS-1:0] forward_speed;
   logic signed [gvr_pkg::SPEED_BITS-1:0] sideways_speed;

   modport source (output valid, yaw_position, diagonal_mode, forward_speed, sideways_speed,
                   input ready);
   modport sink (input valid, yaw_position, diagonal_mode, forward_speed, sideways_speed,
                 output ready);
endinterface

interface gvr_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [gvr_pkg::SPEED_BITS-1:0] forward_speed_rotated;
   logic signed [gvr_pkg::SPEED_BITS-1:0] sideways_speed_rotated;

   modport source (output valid, forward_speed_rotated, sideways_speed_rotated, input ready);
   modport sink (input valid, forward_speed_rotated, sideways_speed_rotated, output ready);
endinterface

interface gvr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [gvr_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [gvr_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/gvr_angle.sv -----
// Zero-position registers and first stage: phase, quadrant and sine/cosine ROM addresses.
module gvr_angle (
   input  logic                    clock,
   input  logic                    reset,
   gvr_csr_if.sink                 csr_chan,
   gvr_req_if.sink                 req_chan,
   output logic                    s1_valid,
   input  logic                    s1_ready,
   output gvr_pkg::angle_word_type s1_word
);

   logic [gvr_pkg::ENCODER_BITS-1:0] common_zero_ff;
   logic [gvr_pkg::ENCODER_BITS-1:0] diagonal_zero_ff;
   logic                             valid_ff;
   gvr_pkg::angle_word_type          word_ff;
   gvr_pkg::angle_word_type          word_in;

   logic                             stage_ready;
   logic [gvr_pkg::ENCODER_BITS-1:0] zero;
   logic [gvr_pkg::ENCODER_BITS-1:0] phase;
   logic [1:0]                       quad;
   logic [gvr_pkg::ADDR_BITS-1:0]    offset;
   logic [gvr_pkg::ADDR_BITS-1:0]    offset_flip;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         common_zero_ff   <= '0;
         diagonal_zero_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            gvr_pkg::REG_COMMON_ZERO: begin
               common_zero_ff <= csr_chan.data[gvr_pkg::ENCODER_BITS-1:0];
            end
            gvr_pkg::REG_DIAGONAL_ZERO: begin
               diagonal_zero_ff <= csr_chan.data[gvr_pkg::ENCODER_BITS-1:0];
            end
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   assign stage_ready    = !valid_ff || s1_ready;
   assign req_chan.ready = stage_ready;

   always_comb begin
      zero        = req_chan.diagonal_mode ? diagonal_zero_ff : common_zero_ff;
      phase       = zero - req_chan.yaw_position;
      quad        = phase[gvr_pkg::ENCODER_BITS-1 -: 2];
      offset      = {1'b0, phase[gvr_pkg::QUARTER_BITS-1:0]};
      offset_flip = gvr_pkg::QUARTER_TURN - offset;

      // odd quadrants read the table backward; cosine is sine one quadrant on
      word_in.sin_addr       = quad[0] ? offset_flip : offset;
      word_in.cos_addr       = quad[0] ? offset : offset_flip;
      word_in.sin_neg        = quad[1];
      word_in.cos_neg        = quad[1] ^ quad[0];
      word_in.forward_speed  = req_chan.forward_speed;
      word_in.sideways_speed = req_chan.sideways_speed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_ready) begin
         valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready) begin
         word_ff <= word_in;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_word  = word_ff;

endmodule

// ----- hw/rtl/gvr_trig.sv -----
// Stages two and three: registered quarter-wave ROM lookups, then signs applied.
module gvr_trig (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    s1_valid,
   output logic                    s1_ready,
   input  gvr_pkg::angle_word_type s1_word,
   output logic                    s3_valid,
   input  logic                    s3_ready,
   output gvr_pkg::trig_word_type  s3_word
);

   localparam gvr_pkg::sine_rom_type SINE_ROM = gvr_pkg::build_sine_rom();

   logic                                     s2_valid_ff;
   logic [gvr_pkg::TRIG_MAG_BITS-1:0]        sin_mag_ff;
   logic [gvr_pkg::TRIG_MAG_BITS-1:0]        cos_mag_ff;
   logic                                     sin_neg_ff;
   logic                                     cos_neg_ff;
   logic signed [gvr_pkg::SPEED_BITS-1:0]    forward_ff;
   logic signed [gvr_pkg::SPEED_BITS-1:0]    sideways_ff;

   logic                                     s3_valid_ff;
   gvr_pkg::trig_word_type                   word_ff;
   gvr_pkg::trig_word_type                   word_in;

   logic                                     s2_ready;
   logic                                     s3_stage_ready;
   logic signed [gvr_pkg::TRIG_BITS-1:0]     sin_ext;
   logic signed [gvr_pkg::TRIG_BITS-1:0]     cos_ext;

   assign s3_stage_ready = !s3_valid_ff || s3_ready;
   assign s2_ready       = !s2_valid_ff || s3_stage_ready;
   assign s1_ready       = s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         sin_mag_ff  <= SINE_ROM[s1_word.sin_addr];
         cos_mag_ff  <= SINE_ROM[s1_word.cos_addr];
         sin_neg_ff  <= s1_word.sin_neg;
         cos_neg_ff  <= s1_word.cos_neg;
         forward_ff  <= s1_word.forward_speed;
         sideways_ff <= s1_word.sideways_speed;
      end
   end

   always_comb begin
      sin_ext                = $signed({1'b0, sin_mag_ff});
      cos_ext                = $signed({1'b0, cos_mag_ff});
      word_in.sine           = sin_neg_ff ? -sin_ext : sin_ext;
      word_in.cosine         = cos_neg_ff ? -cos_ext : cos_ext;
      word_in.forward_speed  = forward_ff;
      word_in.sideways_speed = sideways_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_stage_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_stage_ready) begin
         word_ff <= word_in;
      end
   end

   assign s3_valid = s3_valid_ff;
   assign s3_word  = word_ff;

endmodule

// ----- hw/rtl/gvr_rotate.sv -----
// Stages four to six: four products, the two rotated sums, then scale and saturate.
module gvr_rotate (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   s3_valid,
   output logic                   s3_ready,
   input  gvr_pkg::trig_word_type s3_word,
   gvr_rsp_if.source              rsp_chan
);

   localparam int QUOT_BITS = gvr_pkg::SUM_BITS - gvr_pkg::TRIG_FRACTION_BITS;
   localparam logic signed [QUOT_BITS-1:0] SAT_MAX =
      QUOT_BITS'((1 << (gvr_pkg::SPEED_BITS - 1)) - 1);
   localparam logic signed [QUOT_BITS-1:0] SAT_MIN =
      -QUOT_BITS'(1 << (gvr_pkg::SPEED_BITS - 1));

   logic                                  s4_valid_ff;
   logic signed [gvr_pkg::PROD_BITS-1:0]  fb_cos_ff;
   logic signed [gvr_pkg::PROD_BITS-1:0]  lr_sin_ff;
   logic signed [gvr_pkg::PROD_BITS-1:0]  fb_sin_ff;
   logic signed [gvr_pkg::PROD_BITS-1:0]  lr_cos_ff;

   logic                                  s5_valid_ff;
   logic signed [gvr_pkg::SUM_BITS-1:0]   forward_sum_ff;
   logic signed [gvr_pkg::SUM_BITS-1:0]   sideways_sum_ff;

   logic                                  s6_valid_ff;
   logic signed [gvr_pkg::SPEED_BITS-1:0] forward_ff;
   logic signed [gvr_pkg::SPEED_BITS-1:0] sideways_ff;

   logic                                  s4_ready;
   logic                                  s5_ready;
   logic                                  s6_ready;

   // Divide by 2^F toward zero, then clamp to the speed range.
   function automatic logic signed [gvr_pkg::SPEED_BITS-1:0] scale_sat(
      input logic signed [gvr_pkg::SUM_BITS-1:0] sum
   );
      logic signed [gvr_pkg::SUM_BITS-1:0]   shifted;
      logic signed [QUOT_BITS-1:0]           quot;
      logic                                  round_up;
      logic signed [gvr_pkg::SPEED_BITS-1:0] result;
      shifted  = sum >>> gvr_pkg::TRIG_FRACTION_BITS;
      round_up = sum[gvr_pkg::SUM_BITS-1] && (sum[gvr_pkg::TRIG_FRACTION_BITS-1:0] != '0);
      quot     = shifted[QUOT_BITS-1:0] + $signed({{(QUOT_BITS-1){1'b0}}, round_up});
      if (quot > SAT_MAX) begin
         result = SAT_MAX[gvr_pkg::SPEED_BITS-1:0];
      end else if (quot < SAT_MIN) begin
         result = SAT_MIN[gvr_pkg::SPEED_BITS-1:0];
      end else begin
         result = quot[gvr_pkg::SPEED_BITS-1:0];
      end
      return result;
   endfunction

   assign s6_ready = !s6_valid_ff || rsp_chan.ready;
   assign s5_ready = !s5_valid_ff || s6_ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign s3_ready = s4_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         if (s4_ready) begin
            s4_valid_ff <= s3_valid;
         end
         if (s5_ready) begin
            s5_valid_ff <= s4_valid_ff;
         end
         if (s6_ready) begin
            s6_valid_ff <= s5_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         fb_cos_ff <= gvr_pkg::PROD_BITS'(s3_word.forward_speed) *
                      gvr_pkg::PROD_BITS'(s3_word.cosine);
         lr_sin_ff <= gvr_pkg::PROD_BITS'(s3_word.sideways_speed) *
                      gvr_pkg::PROD_BITS'(s3_word.sine);
         fb_sin_ff <= gvr_pkg::PROD_BITS'(s3_word.forward_speed) *
                      gvr_pkg::PROD_BITS'(s3_word.sine);
         lr_cos_ff <= gvr_pkg::PROD_BITS'(s3_word.sideways_speed) *
                      gvr_pkg::PROD_BITS'(s3_word.cosine);
      end
   end

   always_ff @(posedge clock) begin
      if (s5_ready) begin
         forward_sum_ff  <= gvr_pkg::SUM_BITS'(fb_cos_ff) - gvr_pkg::SUM_BITS'(lr_sin_ff);
         sideways_sum_ff <= gvr_pkg::SUM_BITS'(fb_sin_ff) + gvr_pkg::SUM_BITS'(lr_cos_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (s6_ready) begin
         forward_ff  <= scale_sat(forward_sum_ff);
         sideways_ff <= scale_sat(sideways_sum_ff);
      end
   end

   assign rsp_chan.valid                  = s6_valid_ff;
   assign rsp_chan.forward_speed_rotated  = forward_ff;
   assign rsp_chan.sideways_speed_rotated = sideways_ff;

endmodule

// ----- hw/rtl/gimbal_frame_velocity_rotation_core.sv -----
// Top level: rotates a gimbal-frame speed word into the chassis frame by the yaw encoder angle.
// Six register stages: angle, ROM read, signs, products, sums, then scale and saturate.
// Throughput: one word per cycle while the output is ready; each stage has its own valid bit and
// takes a new word whenever it is empty or its successor moves, so bubbles fill under stall.
// The two sine/cosine ROM reads are both done in stage two on one table.
// Reset clears all stage valid bits and both zero-position registers to 0; no clearing pass.
module gimbal_frame_velocity_rotation_core (
   input  logic       clock,
   input  logic       reset,
   gvr_csr_if.sink    csr_chan,
   gvr_req_if.sink    req_chan,
   gvr_rsp_if.source  rsp_chan
);

   logic                    s1_valid;
   logic                    s1_ready;
   gvr_pkg::angle_word_type s1_word;
   logic                    s3_valid;
   logic                    s3_ready;
   gvr_pkg::trig_word_type  s3_word;

   gvr_angle u_angle (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .req_chan (req_chan),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready),
      .s1_word  (s1_word)
   );

   gvr_trig u_trig (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready),
      .s1_word  (s1_word),
      .s3_valid (s3_valid),
      .s3_ready (s3_ready),
      .s3_word  (s3_word)
   );

   gvr_rotate u_rotate (
      .clock    (clock),
      .reset    (reset),
      .s3_valid (s3_valid),
      .s3_ready (s3_ready),
      .s3_word  (s3_word),
      .rsp_chan (rsp_chan)
   );

endmodule
